FILE: sv/assert_macros.svh
// Assertion macros shared by the stencil RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LBS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be true outside reset.
`define LBS_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: sv/lbs_pkg.sv
// Package with widths, constants and the stencil tap table of the stencil block.
`timescale 1ns / 1ps

package lbs_pkg;

  localparam int unsigned GRID_SIZE_DEF = 64;
  localparam int unsigned COORD_W       = 6;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned WGT_W         = 20;
  localparam int unsigned PROD_W        = DATA_W + WGT_W;
  // The sum of all weight magnitudes is 1070440, so the sum of 37 products
  // stays below 2^53 in magnitude.
  localparam int unsigned ACC_W         = PROD_W + 2;
  localparam int unsigned OUT_W         = 48;

  localparam int unsigned NUM_TAPS      = 37;
  localparam int unsigned TAP_W         = $clog2(NUM_TAPS);

  // Item modes.
  localparam logic MODE_WRITE   = 1'b0;
  localparam logic MODE_COMPUTE = 1'b1;

  // Result is round(-sum / 9216); 9216 = 2^10 * 9.
  localparam int unsigned ROUND_BIAS    = 4608;
  localparam int unsigned DIV_SHIFT     = 10;
  localparam int unsigned DIV_BY        = 9;
  localparam int unsigned RECIP         = 7282;
  localparam int unsigned RECIP_SHIFT   = 16;
  localparam int unsigned DIGIT_W       = 8;
  localparam int unsigned REM_W         = 4;
  localparam int unsigned DIV_STEPS     = OUT_W / DIGIT_W;

  typedef struct packed {
    logic signed [2:0]       dr;
    logic signed [2:0]       dc;
    logic signed [WGT_W-1:0] w;
  } tap_t;

  function automatic tap_t mk_tap(int dr, int dc, int w);
    tap_t t;
    t.dr = 3'(dr);
    t.dc = 3'(dc);
    t.w  = WGT_W'(w);
    return t;
  endfunction

  // Combined weight per tap: 240 * (Laplacian * 60) + 125 * (biharmonic * 180).
  function automatic tap_t tap_info(logic [TAP_W-1:0] k);
    tap_t t;
    case (k)
      6'd0:    t = mk_tap(-3, -1,  -2125);
      6'd1:    t = mk_tap(-3,  0,    500);
      6'd2:    t = mk_tap(-3,  1,  -2125);
      6'd3:    t = mk_tap(-2, -2,  -3625);
      6'd4:    t = mk_tap(-2, -1,  23020);
      6'd5:    t = mk_tap(-2,  0,   5010);
      6'd6:    t = mk_tap(-2,  1,  23020);
      6'd7:    t = mk_tap(-2,  2,  -3625);
      6'd8:    t = mk_tap(-1, -3,  -2125);
      6'd9:    t = mk_tap(-1, -2,  23020);
      6'd10:   t = mk_tap(-1, -1, -42910);
      6'd11:   t = mk_tap(-1,  0, -83020);
      6'd12:   t = mk_tap(-1,  1, -42910);
      6'd13:   t = mk_tap(-1,  2,  23020);
      6'd14:   t = mk_tap(-1,  3,  -2125);
      6'd15:   t = mk_tap( 0, -3,    500);
      6'd16:   t = mk_tap( 0, -2,   5010);
      6'd17:   t = mk_tap( 0, -1, -83020);
      6'd18:   t = mk_tap( 0,  0, 329020);
      6'd19:   t = mk_tap( 0,  1, -83020);
      6'd20:   t = mk_tap( 0,  2,   5010);
      6'd21:   t = mk_tap( 0,  3,    500);
      6'd22:   t = mk_tap( 1, -3,  -2125);
      6'd23:   t = mk_tap( 1, -2,  23020);
      6'd24:   t = mk_tap( 1, -1, -42910);
      6'd25:   t = mk_tap( 1,  0, -83020);
      6'd26:   t = mk_tap( 1,  1, -42910);
      6'd27:   t = mk_tap( 1,  2,  23020);
      6'd28:   t = mk_tap( 1,  3,  -2125);
      6'd29:   t = mk_tap( 2, -2,  -3625);
      6'd30:   t = mk_tap( 2, -1,  23020);
      6'd31:   t = mk_tap( 2,  0,   5010);
      6'd32:   t = mk_tap( 2,  1,  23020);
      6'd33:   t = mk_tap( 2,  2,  -3625);
      6'd34:   t = mk_tap( 3, -1,  -2125);
      6'd35:   t = mk_tap( 3,  0,    500);
      6'd36:   t = mk_tap( 3,  1,  -2125);
      default: t = mk_tap( 0,  0,      0);
    endcase
    return t;
  endfunction

endpackage

FILE: sv/lbs_round_div.sv
// Rounding division of the stencil sum by 9216 with negation and saturation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lbs_round_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [lbs_pkg::ACC_W-1:0] sum_i,
  output logic                             done_o,
  output logic        [lbs_pkg::OUT_W-1:0] derivative_o,
  output logic                             saturated_o
);

  localparam int unsigned AccW   = lbs_pkg::ACC_W;
  localparam int unsigned OutW   = lbs_pkg::OUT_W;
  localparam int unsigned DigW   = lbs_pkg::DIGIT_W;
  localparam int unsigned RemW   = lbs_pkg::REM_W;
  localparam int unsigned VW     = RemW + DigW;
  localparam int unsigned PW     = 2 * VW;
  localparam int unsigned CntW   = $clog2(lbs_pkg::DIV_STEPS);

  typedef enum logic [3:0] {
    D_IDLE  = 4'b0001,
    D_ROUND = 4'b0010,
    D_STEP  = 4'b0100,
    D_FIN   = 4'b1000
  } dstate_e;

  dstate_e          state_q, state_d;
  logic [AccW-1:0]  mag_q, mag_d;
  logic             neg_q, neg_d;
  logic [OutW-1:0]  div_q, div_d;
  logic [RemW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [OutW-1:0]  res_q, res_d;
  logic             sat_q, sat_d;

  logic [AccW:0]    rnd;
  logic [VW-1:0]    v;
  logic [PW-1:0]    prod;
  logic [DigW-1:0]  qd;

  always_comb begin
    rnd  = (AccW+1)'(mag_q) + (AccW+1)'(lbs_pkg::ROUND_BIAS);
    v    = {rem_q, div_q[OutW-1 -: DigW]};
    // Quotient digit of v / 9 by reciprocal; exact for all v below 9 * 256.
    prod = PW'(v) * PW'(lbs_pkg::RECIP);
    qd   = prod[lbs_pkg::RECIP_SHIFT +: DigW];
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    neg_d   = neg_q;
    div_d   = div_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    res_d   = res_q;
    sat_d   = sat_q;
    unique case (state_q)
      D_IDLE: begin
        if (start_i) begin
          mag_d   = sum_i[AccW-1] ? AccW'(-sum_i) : AccW'(sum_i);
          // The result is negated exactly when the sum is positive.
          neg_d   = !sum_i[AccW-1] && (sum_i != '0);
          state_d = D_ROUND;
        end
      end
      D_ROUND: begin
        div_d   = OutW'(rnd >> lbs_pkg::DIV_SHIFT);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = D_STEP;
      end
      D_STEP: begin
        rem_d = RemW'(v - VW'(qd) * VW'(lbs_pkg::DIV_BY));
        div_d = {div_q[OutW-DigW-1:0], qd};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(lbs_pkg::DIV_STEPS - 1)) begin
          state_d = D_FIN;
        end
      end
      D_FIN: begin
        sat_d = 1'b0;
        if (!neg_q && div_q[OutW-1]) begin
          res_d = {1'b0, {(OutW-1){1'b1}}};
          sat_d = 1'b1;
        end else if (neg_q && div_q[OutW-1] && (div_q[OutW-2:0] != '0)) begin
          res_d = {1'b1, {(OutW-1){1'b0}}};
          sat_d = 1'b1;
        end else begin
          res_d = neg_q ? OutW'(-div_q) : div_q;
        end
        done_d  = 1'b1;
        state_d = D_IDLE;
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    neg_q <= neg_d;
    div_q <= div_d;
    rem_q <= rem_d;
    res_q <= res_d;
    sat_q <= sat_d;
  end

  assign done_o       = done_q;
  assign derivative_o = res_q;
  assign saturated_o  = sat_q;

  `LBS_ASSERT(a_rem_below_divisor, state_q == D_STEP |-> rem_q < RemW'(lbs_pkg::DIV_BY), "division remainder out of range")
  `LBS_ASSERT(a_done_returns_idle, done_q |-> state_q == D_IDLE, "divider done outside idle")
  `LBS_ASSERT_NEVER(a_no_saturation, done_q && sat_q, "stencil sum exceeded the result range")

endmodule

FILE: sv/laplacian_biharmonic_stencil.sv
// Laplacian plus biharmonic stencil on a toroidal grid held in one memory.
//
// Input channel (in_valid_i / in_ready_o): mode_i = 0 stores cell_value_i at
// (row_i, col_i); mode_i = 1 evaluates -(L/0.64 + B/0.4096) at that cell.
// Coordinates are reduced modulo GRID_SIZE and neighbors wrap at both edges.
// Output channel (out_valid_o / out_ready_i): one transfer per compute item
// with derivative_o (Q24.24) and saturated_o; write items give no transfer.
// A write is stored as it is accepted. A compute walks 37 taps through the
// single read port of the grid memory, one tap per cycle, then a three-stage
// read, multiply and accumulate drain, and a digit-serial rounding divide;
// the next item is taken once the result is in the output register.
// The output register holds one result; while the receiver stalls, new items
// (writes too) are still accepted, but the next compute finishes only after
// that result has been transferred. Reset empties the control path and the
// output register; grid cells read back only after they have been written.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module laplacian_biharmonic_stencil #(
  parameter int unsigned GRID_SIZE = lbs_pkg::GRID_SIZE_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               mode_i,
  input  logic        [lbs_pkg::COORD_W-1:0] row_i,
  input  logic        [lbs_pkg::COORD_W-1:0] col_i,
  input  logic signed [lbs_pkg::DATA_W-1:0]  cell_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [lbs_pkg::OUT_W-1:0]   derivative_o,
  output logic                               saturated_o
);

  localparam int unsigned CW       = lbs_pkg::COORD_W;
  localparam int unsigned RW       = $clog2(GRID_SIZE);
  localparam int unsigned MW       = ((RW > CW) ? RW : CW) + 1;
  localparam int unsigned Depth    = GRID_SIZE * GRID_SIZE;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned ModSteps = (2**CW + GRID_SIZE - 1) / GRID_SIZE;
  localparam int unsigned TW       = lbs_pkg::TAP_W;
  localparam int unsigned DW       = lbs_pkg::DATA_W;
  localparam int unsigned PW       = lbs_pkg::PROD_W;
  localparam int unsigned AccW     = lbs_pkg::ACC_W;
  localparam int unsigned OutW     = lbs_pkg::OUT_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ISSUE = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  function automatic logic [RW-1:0] reduce_coord(logic [CW-1:0] c);
    logic [MW-1:0] m;
    m = MW'(c);
    for (int i = 0; i < ModSteps; i++) begin
      if (m >= MW'(GRID_SIZE)) m = m - MW'(GRID_SIZE);
    end
    return m[RW-1:0];
  endfunction

  // Offsets stay within three cells, so one correction in each direction wraps.
  function automatic logic [RW-1:0] wrap_coord(logic [RW-1:0] c, logic signed [2:0] d);
    logic [RW+1:0] s;
    s = (RW+2)'(c) + (RW+2)'(GRID_SIZE) + {{(RW-1){d[2]}}, d};
    if (s >= (RW+2)'(2 * GRID_SIZE)) begin
      s = s - (RW+2)'(2 * GRID_SIZE);
    end else if (s >= (RW+2)'(GRID_SIZE)) begin
      s = s - (RW+2)'(GRID_SIZE);
    end
    return s[RW-1:0];
  endfunction

  state_e                 state_q, state_d;
  logic [RW-1:0]          row_q, row_d, col_q, col_d;
  logic [TW-1:0]          tap_q, tap_d;
  logic                   a_v_q, a_v_d;
  logic [TW-1:0]          a_tap_q;
  logic [AW-1:0]          addr_q, addr_d;
  logic                   r_v_q;
  logic [TW-1:0]          r_tap_q;
  logic signed [DW-1:0]   rdata_q;
  logic                   p_v_q;
  logic signed [PW-1:0]   p_q, p_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   out_valid_q, out_valid_d;
  logic [OutW-1:0]        derivative_q;
  logic                   saturated_q;

  logic                   in_xfer;
  logic                   mem_we;
  logic [AW-1:0]          wr_addr;
  logic [RW-1:0]          row_red, col_red;
  lbs_pkg::tap_t          tap_iss, tap_mul;
  logic                   div_start, div_done;
  logic [OutW-1:0]        div_deriv;
  logic                   div_sat;
  logic                   out_load;

  logic [DW-1:0]          grid_mem [Depth];

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign row_red    = reduce_coord(row_i);
  assign col_red    = reduce_coord(col_i);
  assign wr_addr    = AW'(row_red) * AW'(GRID_SIZE) + AW'(col_red);
  assign mem_we     = in_xfer && (mode_i == lbs_pkg::MODE_WRITE);

  assign tap_iss = lbs_pkg::tap_info(tap_q);
  assign tap_mul = lbs_pkg::tap_info(r_tap_q);
  assign addr_d  = AW'(wrap_coord(row_q, tap_iss.dr)) * AW'(GRID_SIZE)
                 + AW'(wrap_coord(col_q, tap_iss.dc));
  assign p_d     = rdata_q * tap_mul.w;
  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    col_d     = col_q;
    tap_d     = tap_q;
    acc_d     = acc_q;
    a_v_d     = 1'b0;
    div_start = 1'b0;
    if (p_v_q) begin
      acc_d = acc_q + AccW'(p_q);
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer && (mode_i == lbs_pkg::MODE_COMPUTE)) begin
          row_d   = row_red;
          col_d   = col_red;
          tap_d   = '0;
          acc_d   = '0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        a_v_d = 1'b1;
        tap_d = tap_q + 1'b1;
        if (tap_q == TW'(lbs_pkg::NUM_TAPS - 1)) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The sum is complete once the read and multiply stages are empty.
        if (!a_v_q && !r_v_q && !p_v_q) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      a_v_q       <= 1'b0;
      r_v_q       <= 1'b0;
      p_v_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tap_q       <= tap_d;
      a_v_q       <= a_v_d;
      r_v_q       <= a_v_q;
      p_v_q       <= r_v_q;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    col_q   <= col_d;
    acc_q   <= acc_d;
    addr_q  <= addr_d;
    a_tap_q <= tap_q;
    r_tap_q <= a_tap_q;
    p_q     <= p_d;
    if (out_load) begin
      derivative_q <= div_deriv;
      saturated_q  <= div_sat;
    end
  end

  // Grid memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[wr_addr] <= cell_value_i;
    end
    if (a_v_q) begin
      rdata_q <= grid_mem[addr_q];
    end
  end

  lbs_round_div u_round_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (div_start),
    .sum_i        (acc_q),
    .done_o       (div_done),
    .derivative_o (div_deriv),
    .saturated_o  (div_sat)
  );

  assign out_valid_o  = out_valid_q;
  assign derivative_o = derivative_q;
  assign saturated_o  = saturated_q;

  `LBS_ASSERT(a_read_only_in_compute, a_v_q |-> state_q == S_ISSUE || state_q == S_DRAIN, "grid read outside a compute")
  `LBS_ASSERT_NEVER(a_no_accept_while_busy, in_ready_o && (a_v_q || r_v_q || p_v_q), "input taken with reads in flight")
  `LBS_ASSERT(a_div_done_in_div, div_done |-> state_q == S_DIV, "divider finished outside its state")
  `LBS_ASSERT(a_load_sets_valid, out_load |=> out_valid_q, "loaded result not offered")

endmodule

FILE: sim/tb_laplacian_biharmonic_stencil.sv
// Testbench for the stencil block: partial prefill, directed and random items, predictor.
`timescale 1ns / 1ps
module tb_laplacian_biharmonic_stencil;

  localparam int GRID = lbs_pkg::GRID_SIZE_DEF;
  localparam int CW = lbs_pkg::COORD_W;
  localparam int DW = lbs_pkg::DATA_W;
  localparam int OW = lbs_pkg::OUT_W;
  localparam int RANDOM_ITEMS = 780;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ROUND_HALF = 4608;
  localparam int ROUND_DIV = 9216;
  localparam int SQUARE_LO = -8;
  localparam int SQUARE_HI = 7;
  localparam logic signed [DW-1:0] CELL_MAX = 32'sh7fffffff;
  localparam logic signed [DW-1:0] CELL_MIN = 32'sh80000000;
  localparam longint DERIV_MAX = (longint'(1) <<< (OW - 1)) - 1;
  localparam longint DERIV_MIN = -(longint'(1) <<< (OW - 1));

  typedef struct packed {
    logic mode;
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic signed [DW-1:0] value;
  } stencil_item_t;

  typedef struct packed {
    logic [CW-1:0] row;
    logic [CW-1:0] col;
    logic signed [OW-1:0] derivative;
    logic saturated;
  } derivative_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic mode_i = lbs_pkg::MODE_WRITE;
  logic [CW-1:0] row_i = '0;
  logic [CW-1:0] col_i = '0;
  logic signed [DW-1:0] cell_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OW-1:0] derivative_o;
  logic saturated_o;

  stencil_item_t pending_items[$];
  derivative_t expected_derivs[$];
  logic signed [DW-1:0] grid_model [GRID*GRID];

  int items_queued = 0;
  int items_accepted = 0;
  int errors = 0;
  int cycle_count = 0;
  int sender_idle_pct = 24;
  int receiver_idle_pct = 47;
  int hold_left = 0;
  bit long_hold_req = 1'b0;
  bit item_taken = 1'b0;
  stencil_item_t next_item;
  derivative_t oldest_deriv;

  laplacian_biharmonic_stencil uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .mode_i(mode_i),
    .row_i(row_i),
    .col_i(col_i),
    .cell_value_i(cell_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .derivative_o(derivative_o),
    .saturated_o(saturated_o)
  );

  // Weights depend only on the sorted absolute offsets; the key is lo * 4 + hi.
  function automatic longint tap_weight(int dr, int dc);
    int a;
    int b;
    int key;
    longint lap60;
    longint bih180;
    a = (dr < 0) ? -dr : dr;
    b = (dc < 0) ? -dc : dc;
    key = (a < b) ? a * 4 + b : b * 4 + a;
    case (key)
      0: lap60 = -252;
      1: lap60 = 52;
      5: lap60 = 16;
      2: lap60 = -1;
      6: lap60 = -2;
      default: lap60 = 0;
    endcase
    case (key)
      0: bih180 = 3116;
      1: bih180 = -764;
      5: bih180 = -374;
      2: bih180 = 42;
      6: bih180 = 188;
      10: bih180 = -29;
      3: bih180 = 4;
      7: bih180 = -17;
      default: bih180 = 0;
    endcase
    return 240 * lap60 + 125 * bih180;
  endfunction

  function automatic derivative_t predict_derivative(logic [CW-1:0] r, logic [CW-1:0] c);
    derivative_t res;
    longint acc;
    longint q;
    int rr;
    int cc;
    acc = 0;
    for (int dr = -3; dr <= 3; dr++) begin
      for (int dc = -3; dc <= 3; dc++) begin
        rr = (int'(r) + GRID + dr) % GRID;
        cc = (int'(c) + GRID + dc) % GRID;
        acc += longint'(grid_model[rr*GRID+cc]) * tap_weight(dr, dc);
      end
    end
    acc = -acc;
    // Round half away from zero.
    if (acc >= 0) begin
      q = (acc + ROUND_HALF) / ROUND_DIV;
    end else begin
      q = -((-acc + ROUND_HALF) / ROUND_DIV);
    end
    res.saturated = 1'b0;
    if (q > DERIV_MAX) begin
      q = DERIV_MAX;
      res.saturated = 1'b1;
    end
    if (q < DERIV_MIN) begin
      q = DERIV_MIN;
      res.saturated = 1'b1;
    end
    res.row = r;
    res.col = c;
    res.derivative = q[OW-1:0];
    return res;
  endfunction

  // Signed offset of a from center on the torus, in -GRID/2 .. GRID/2-1.
  function automatic int wrap_delta(int a, int center);
    return ((a - center + GRID + GRID / 2) % GRID) - GRID / 2;
  endfunction

  function automatic bit in_window(int r, int c, int cr, int cc);
    int dr;
    int dc;
    dr = wrap_delta(r, cr);
    dc = wrap_delta(c, cc);
    return (dr >= -3) && (dr <= 3) && (dc >= -3) && (dc <= 3);
  endfunction

  // A 16 x 16 block of written cells; any center from five cells before to four
  // cells after cr, cc in each direction reads only cells inside it.
  function automatic bit in_square(int r, int c, int cr, int cc);
    int dr;
    int dc;
    dr = wrap_delta(r, cr);
    dc = wrap_delta(c, cc);
    return (dr >= SQUARE_LO) && (dr <= SQUARE_HI) && (dc >= SQUARE_LO) && (dc <= SQUARE_HI);
  endfunction

  function automatic bit in_prefill(int r, int c);
    return in_square(r, c, 0, 0) || in_square(r, c, 32, 32) ||
           in_window(r, c, 16, 48) || in_window(r, c, 48, 16);
  endfunction

  function automatic logic signed [DW-1:0] random_cell_value();
    case ($urandom_range(0, 15))
      0: return CELL_MAX;
      1: return CELL_MIN;
      2: return '0;
      3: return 32'sd1;
      4: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Around (0,0) each cell takes the extreme with the sign of its weight, so the sum peaks.
  function automatic logic signed [DW-1:0] prefill_value(int r, int c);
    longint w;
    if (in_window(r, c, 0, 0)) begin
      w = tap_weight(wrap_delta(r, 0), wrap_delta(c, 0));
      if (w > 0) return CELL_MAX;
      if (w < 0) return CELL_MIN;
    end
    if (in_window(r, c, 32, 32)) return '0;
    if (in_window(r, c, 16, 48)) return CELL_MAX;
    if (in_window(r, c, 48, 16)) return CELL_MIN;
    return random_cell_value();
  endfunction

  task automatic queue_item(logic mode, int r, int c, logic signed [DW-1:0] v);
    stencil_item_t it;
    it.mode = mode;
    it.row = CW'(r);
    it.col = CW'(c);
    it.value = v;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic wait_for_drain();
    while (items_accepted != items_queued || expected_derivs.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("laplacian_biharmonic_stencil: mismatch");
      $finish;
    end
  end

  // Sender: a new item is presented only when the line is free or the last one transferred.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || item_taken) begin
        item_taken = 1'b0;
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          next_item = pending_items.pop_front();
          mode_i <= next_item.mode;
          row_i <= next_item.row;
          col_i <= next_item.col;
          cell_value_i <= next_item.value;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver, with an optional long hold-off counted here.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
    end
  end

  // Output check first, then the input transfer updates the grid or queues a prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_derivs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0d saturated %0b",
                   $time, derivative_o, saturated_o);
        end else begin
          oldest_deriv = expected_derivs.pop_front();
          if (derivative_o !== oldest_deriv.derivative) begin
            errors++;
            $display("%0t: derivative at (%0d,%0d) expected %0d actual %0d", $time,
                     oldest_deriv.row, oldest_deriv.col,
                     $signed(oldest_deriv.derivative), derivative_o);
          end
          if (saturated_o !== oldest_deriv.saturated) begin
            errors++;
            $display("%0t: saturated at (%0d,%0d) expected %0b actual %0b", $time,
                     oldest_deriv.row, oldest_deriv.col, oldest_deriv.saturated,
                     saturated_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        items_accepted++;
        item_taken = 1'b1;
        if (mode_i == lbs_pkg::MODE_WRITE) begin
          grid_model[int'(row_i)*GRID+int'(col_i)] = cell_value_i;
        end else begin
          expected_derivs.push_back(predict_derivative(row_i, col_i));
        end
      end
    end
  end

  initial begin
    int base;
    int off_r;
    int off_c;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Every cell that a compute reads is written before that compute.
    for (int r = 0; r < GRID; r++) begin
      for (int c = 0; c < GRID; c++) begin
        if (in_prefill(r, c)) begin
          queue_item(lbs_pkg::MODE_WRITE, r, c, prefill_value(r, c));
        end
      end
    end

    queue_item(lbs_pkg::MODE_COMPUTE, 0, 0, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 32, 32, CELL_MAX);
    queue_item(lbs_pkg::MODE_COMPUTE, 16, 48, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 48, 16, CELL_MIN);
    queue_item(lbs_pkg::MODE_COMPUTE, 63, 63, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 0, 63, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 63, 0, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 2, 61, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 31, 35, '0);
    queue_item(lbs_pkg::MODE_WRITE, 0, 0, CELL_MIN);
    queue_item(lbs_pkg::MODE_COMPUTE, 0, 0, '0);
    queue_item(lbs_pkg::MODE_WRITE, 0, 0, '0);
    queue_item(lbs_pkg::MODE_COMPUTE, 1, 1, '0);
    queue_item(lbs_pkg::MODE_WRITE, 63, 63, CELL_MAX);
    queue_item(lbs_pkg::MODE_COMPUTE, 63, 63, '0);

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        sender_idle_pct = 47;
        receiver_idle_pct = 24;
      end else if (phase == 2) begin
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        // The receiver stalls while items keep coming, so the input backs up.
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
        if ($urandom_range(0, 99) < 40) begin
          queue_item(lbs_pkg::MODE_WRITE, $urandom_range(0, GRID - 1),
                     $urandom_range(0, GRID - 1), random_cell_value());
        end else begin
          // Centers stay close enough to a prefilled block that every read is written.
          base = ($urandom_range(0, 1) == 0) ? 0 : GRID / 2;
          off_r = int'($urandom_range(0, 9)) - 5;
          off_c = int'($urandom_range(0, 9)) - 5;
          queue_item(lbs_pkg::MODE_COMPUTE, (base + off_r + GRID) % GRID,
                     (base + off_c + GRID) % GRID, $urandom);
        end
      end
      wait_for_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("laplacian_biharmonic_stencil: match");
    end else begin
      $display("laplacian_biharmonic_stencil: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/lbs_pkg.sv
sv/lbs_round_div.sv
sv/laplacian_biharmonic_stencil.sv
sim/tb_laplacian_biharmonic_stencil.sv
